@@ design/segx_pkg.sv @@
// Shared types and constants for the 2D segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package segx_pkg;

   // stages ahead of the divider: input, products, differences,
   // partial products, numerators, magnitudes
   localparam int FRONT_STAGES = 6;
   // stages after the divider: sign restore, range check and output
   localparam int TAIL_STAGES  = 2;

   typedef struct packed {
      logic ovf;   // quotient magnitude reaches 2^COORD_BITS
   } div_flags_type;

endpackage
`default_nettype wire

@@ design/segx_chan_if.sv @@
// Valid/ready channels carrying segment pairs in and intersection results out.
`timescale 1ns / 1ps
`default_nettype none
interface segx_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_start_x;
   logic signed [COORD_BITS-1:0] a_start_y;
   logic signed [COORD_BITS-1:0] a_end_x;
   logic signed [COORD_BITS-1:0] a_end_y;
   logic signed [COORD_BITS-1:0] b_start_x;
   logic signed [COORD_BITS-1:0] b_start_y;
   logic signed [COORD_BITS-1:0] b_end_x;
   logic signed [COORD_BITS-1:0] b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segx_rsp_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic signed [COORD_BITS-1:0] cross_x;
   logic signed [COORD_BITS-1:0] cross_y;

   modport source (output valid, hit, cross_x, cross_y, input ready);
   modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

@@ design/segx_div_lane.sv @@
// Pipelined restoring divider lane: one quotient bit per stage, with overflow check.
`timescale 1ns / 1ps
`default_nettype none
module segx_div_lane
   import segx_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int NUM_BITS   = 75,
   parameter int DEN_BITS   = 51
) (
   input  wire logic                  clock,
   input  wire logic [COORD_BITS:0]   en,
   input  wire logic [NUM_BITS-1:0]   num,
   input  wire logic [DEN_BITS-1:0]   den,
   output      logic [COORD_BITS-1:0] quo,
   output      div_flags_type         flags
);

   logic [NUM_BITS-1:0]   r_ff   [COORD_BITS+1];
   logic [DEN_BITS-1:0]   den_ff [COORD_BITS+1];
   logic [COORD_BITS-1:0] q_ff   [COORD_BITS+1];
   logic                  ovf_ff [COORD_BITS+1];
   logic [NUM_BITS-1:0]   lim;

   // quotient fits in COORD_BITS bits only below den * 2^COORD_BITS
   assign lim = NUM_BITS'(den) << COORD_BITS;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (num >= lim);
      end
   end

   for (genvar j = 1; j <= COORD_BITS; j++) begin : g_step
      logic [NUM_BITS-1:0] trial;
      assign trial = NUM_BITS'(den_ff[j-1]) << (COORD_BITS - j);

      always_ff @(posedge clock) begin
         if (en[j]) begin
            den_ff[j] <= den_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            if (r_ff[j-1] >= trial) begin
               r_ff[j] <= r_ff[j-1] - trial;
               q_ff[j] <= q_ff[j-1] | (COORD_BITS'(1) << (COORD_BITS - j));
            end else begin
               r_ff[j] <= r_ff[j-1];
               q_ff[j] <= q_ff[j-1];
            end
         end
      end
   end

   assign quo       = q_ff[COORD_BITS];
   assign flags.ovf = ovf_ff[COORD_BITS];

endmodule
`default_nettype wire

@@ design/segment_intersection_2d_top.sv @@
// Top level of the fixed-point 2D segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one segment pair per cycle while req.ready is high and returns one
// result per pair, in order. Six front stages form the determinant and both
// numerators, then COORD_BITS + 1 divider stages (an overflow check plus one
// quotient bit per stage, x and y in parallel lanes), then sign restore and
// the range check into the output register. Every stage holds its own valid
// bit, so a stalled output freezes only the full stages that run up to it;
// stages behind a bubble keep moving, and input is taken while any stage is empty.
// A zero determinant, a quotient overflow or a crossing point outside either
// segment's x or y range gives hit = 0 with both coordinates zero.
module segment_intersection_2d_top
   import segx_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   segx_req_if.sink   req,
   segx_rsp_if.source rsp
);

   localparam int C    = COORD_BITS;
   localparam int DW   = C + 1;          // coordinate differences
   localparam int PRW  = 2 * C + 2;      // difference products
   localparam int DETW = 2 * C + 3;      // determinant
   localparam int PW   = 2 * C + 1;      // pre / post cross products
   localparam int NW   = 3 * C + 3;      // numerators
   localparam int DIV0 = FRONT_STAGES;
   localparam int NS   = FRONT_STAGES + C + 1 + TAIL_STAGES;

   typedef struct packed {
      logic signed [C-1:0] xa_lo, xa_hi, ya_lo, ya_hi;
      logic signed [C-1:0] xb_lo, xb_hi, yb_lo, yb_hi;
      logic                xneg, yneg, dz;
   } side_type;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] adv;
   side_type      sb_ff [NS-1];
   side_type      sb_in;

   // a stage moves when the output drains or some stage at or after it is empty
   for (genvar i = 0; i < NS; i++) begin : g_adv
      assign adv[i] = rsp.ready | ~(&vld_ff[NS-1:i]);
   end

   assign vld_in = {vld_ff[NS-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req.ready = adv[0];

   // ---------------- stage 0: capture, differences, ranges
   logic signed [C-1:0]  x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;
   logic signed [DW-1:0] dxa0_ff, dya0_ff, dxb0_ff, dyb0_ff;

   always_comb begin
      sb_in       = '0;
      sb_in.xa_lo = (req.a_start_x < req.a_end_x) ? req.a_start_x : req.a_end_x;
      sb_in.xa_hi = (req.a_start_x < req.a_end_x) ? req.a_end_x : req.a_start_x;
      sb_in.ya_lo = (req.a_start_y < req.a_end_y) ? req.a_start_y : req.a_end_y;
      sb_in.ya_hi = (req.a_start_y < req.a_end_y) ? req.a_end_y : req.a_start_y;
      sb_in.xb_lo = (req.b_start_x < req.b_end_x) ? req.b_start_x : req.b_end_x;
      sb_in.xb_hi = (req.b_start_x < req.b_end_x) ? req.b_end_x : req.b_start_x;
      sb_in.yb_lo = (req.b_start_y < req.b_end_y) ? req.b_start_y : req.b_end_y;
      sb_in.yb_hi = (req.b_start_y < req.b_end_y) ? req.b_end_y : req.b_start_y;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x1_ff   <= req.a_start_x;
         y1_ff   <= req.a_start_y;
         x2_ff   <= req.a_end_x;
         y2_ff   <= req.a_end_y;
         x3_ff   <= req.b_start_x;
         y3_ff   <= req.b_start_y;
         x4_ff   <= req.b_end_x;
         y4_ff   <= req.b_end_y;
         dxa0_ff <= DW'(req.a_start_x) - DW'(req.a_end_x);
         dya0_ff <= DW'(req.a_start_y) - DW'(req.a_end_y);
         dxb0_ff <= DW'(req.b_start_x) - DW'(req.b_end_x);
         dyb0_ff <= DW'(req.b_start_y) - DW'(req.b_end_y);
         sb_ff[0] <= sb_in;
      end
   end

   // carry the side band; flags are filled in at the magnitude stage
   for (genvar i = 1; i < NS - 1; i++) begin : g_side
      if (i != DIV0 - 1) begin : g_copy
         always_ff @(posedge clock) begin
            if (adv[i]) begin
               sb_ff[i] <= sb_ff[i-1];
            end
         end
      end
   end

   // ---------------- stage 1: products
   logic signed [PRW-1:0] dd1_ff, dd2_ff;
   logic signed [2*C-1:0] p1_ff, p2_ff, q1_ff, q2_ff;
   logic signed [DW-1:0]  dxa1_ff, dya1_ff, dxb1_ff, dyb1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         dd1_ff  <= dxa0_ff * dyb0_ff;
         dd2_ff  <= dya0_ff * dxb0_ff;
         p1_ff   <= x1_ff * y2_ff;
         p2_ff   <= y1_ff * x2_ff;
         q1_ff   <= x3_ff * y4_ff;
         q2_ff   <= y3_ff * x4_ff;
         dxa1_ff <= dxa0_ff;
         dya1_ff <= dya0_ff;
         dxb1_ff <= dxb0_ff;
         dyb1_ff <= dyb0_ff;
      end
   end

   // ---------------- stage 2: determinant, pre, post
   logic signed [DETW-1:0] d2_ff;
   logic signed [PW-1:0]   pre_ff, post_ff;
   logic signed [DW-1:0]   dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         d2_ff   <= DETW'(dd1_ff) - DETW'(dd2_ff);
         pre_ff  <= PW'(p1_ff) - PW'(p2_ff);
         post_ff <= PW'(q1_ff) - PW'(q2_ff);
         dxa2_ff <= dxa1_ff;
         dya2_ff <= dya1_ff;
         dxb2_ff <= dxb1_ff;
         dyb2_ff <= dyb1_ff;
      end
   end

   // ---------------- stage 3: partial products of the numerators
   logic signed [C-1:0]     pre_hi, post_hi;
   logic signed [C+1:0]     pre_lo, post_lo;
   logic signed [2*C:0]     hxb_ff, hyb_ff, hxa_ff, hya_ff;
   logic signed [2*C+2:0]   lxb_ff, lyb_ff, lxa_ff, lya_ff;
   logic signed [DETW-1:0]  d3_ff;

   assign pre_hi  = pre_ff[2*C:C+1];
   assign post_hi = post_ff[2*C:C+1];
   assign pre_lo  = $signed({1'b0, pre_ff[C:0]});
   assign post_lo = $signed({1'b0, post_ff[C:0]});

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         hxb_ff <= pre_hi * dxb2_ff;
         lxb_ff <= pre_lo * dxb2_ff;
         hyb_ff <= pre_hi * dyb2_ff;
         lyb_ff <= pre_lo * dyb2_ff;
         hxa_ff <= post_hi * dxa2_ff;
         lxa_ff <= post_lo * dxa2_ff;
         hya_ff <= post_hi * dya2_ff;
         lya_ff <= post_lo * dya2_ff;
         d3_ff  <= d2_ff;
      end
   end

   // ---------------- stage 4: numerators
   logic signed [2*C+1:0] hx_diff, hy_diff;
   logic signed [2*C+3:0] lx_diff, ly_diff;
   logic signed [NW-1:0]  nx_ff, ny_ff;
   logic signed [DETW-1:0] d4_ff;

   assign hx_diff = (2*C+2)'(hxb_ff) - (2*C+2)'(hxa_ff);
   assign hy_diff = (2*C+2)'(hyb_ff) - (2*C+2)'(hya_ff);
   assign lx_diff = (2*C+4)'(lxb_ff) - (2*C+4)'(lxa_ff);
   assign ly_diff = (2*C+4)'(lyb_ff) - (2*C+4)'(lya_ff);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         nx_ff <= (NW'(hx_diff) <<< (C + 1)) + NW'(lx_diff);
         ny_ff <= (NW'(hy_diff) <<< (C + 1)) + NW'(ly_diff);
         d4_ff <= d3_ff;
      end
   end

   // ---------------- stage 5: magnitudes and signs
   logic [NW-1:0]   nxa_ff, nya_ff;
   logic [DETW-1:0] da_ff;
   side_type        sb5_in;

   always_comb begin
      sb5_in      = sb_ff[DIV0-2];
      sb5_in.xneg = nx_ff[NW-1] ^ d4_ff[DETW-1];
      sb5_in.yneg = ny_ff[NW-1] ^ d4_ff[DETW-1];
      sb5_in.dz   = (d4_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv[DIV0-1]) begin
         nxa_ff          <= nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
         nya_ff          <= ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
         da_ff           <= d4_ff[DETW-1] ? DETW'(-d4_ff) : DETW'(d4_ff);
         sb_ff[DIV0-1]   <= sb5_in;
      end
   end

   // ---------------- divider lanes
   logic [C-1:0]   qx, qy;
   div_flags_type  fx, fy;

   segx_div_lane #(
      .COORD_BITS (C),
      .NUM_BITS   (NW),
      .DEN_BITS   (DETW)
   ) u_div_x (
      .clock (clock),
      .en    (adv[DIV0 +: C+1]),
      .num   (nxa_ff),
      .den   (da_ff),
      .quo   (qx),
      .flags (fx)
   );

   segx_div_lane #(
      .COORD_BITS (C),
      .NUM_BITS   (NW),
      .DEN_BITS   (DETW)
   ) u_div_y (
      .clock (clock),
      .en    (adv[DIV0 +: C+1]),
      .num   (nya_ff),
      .den   (da_ff),
      .quo   (qy),
      .flags (fy)
   );

   // ---------------- sign restore
   logic signed [C:0] sx_ff, sy_ff;
   logic              ok_ff;
   side_type          sbq;

   assign sbq = sb_ff[NS-3];

   always_ff @(posedge clock) begin
      if (adv[NS-2]) begin
         sx_ff <= sbq.xneg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
         sy_ff <= sbq.yneg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
         ok_ff <= !sbq.dz && !fx.ovf && !fy.ovf;
      end
   end

   // ---------------- range check and output register
   side_type          sbo;
   logic              in_rng;
   logic              hit_ff;
   logic signed [C-1:0] cx_ff, cy_ff;

   assign sbo = sb_ff[NS-2];

   always_comb begin
      in_rng = ok_ff
             && (sx_ff >= (C+1)'(sbo.xa_lo)) && (sx_ff <= (C+1)'(sbo.xa_hi))
             && (sx_ff >= (C+1)'(sbo.xb_lo)) && (sx_ff <= (C+1)'(sbo.xb_hi))
             && (sy_ff >= (C+1)'(sbo.ya_lo)) && (sy_ff <= (C+1)'(sbo.ya_hi))
             && (sy_ff >= (C+1)'(sbo.yb_lo)) && (sy_ff <= (C+1)'(sbo.yb_hi));
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         hit_ff <= in_rng;
         cx_ff  <= in_rng ? sx_ff[C-1:0] : '0;
         cy_ff  <= in_rng ? sy_ff[C-1:0] : '0;
      end
   end

   assign rsp.valid   = vld_ff[NS-1];
   assign rsp.hit     = hit_ff;
   assign rsp.cross_x = cx_ff;
   assign rsp.cross_y = cy_ff;

endmodule
`default_nettype wire
